[rtl/rcm_pkg.sv]
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared constants, codes, control structs and helpers for the rotor cipher.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int MAX_ROTORS    = 4;
  localparam int ALPHABET_SIZE = 94;
  localparam int FIRST_CHAR    = 33;
  localparam int LAST_CHAR     = FIRST_CHAR + ALPHABET_SIZE - 1;
  localparam int NUM_PLUG_REGS = 6;

  localparam int ROT_W     = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
  localparam int IDX_W     = 7;
  localparam int MAP_DEPTH = MAX_ROTORS * ALPHABET_SIZE;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int LBL_AW    = $clog2(ALPHABET_SIZE);
  localparam int LBL_W     = 8;

  // command codes of the input channel
  typedef enum logic [1:0] {
    CMD_LOAD_ROTOR = 2'd0,
    CMD_LOAD_LABEL = 2'd1,
    CMD_SET_START  = 2'd2,
    CMD_TRANSLATE  = 2'd3
  } cmd_t;

  // register indexes of the configuration port
  localparam logic [2:0] REG_ROTORS        = 3'd0;
  localparam logic [2:0] REG_PLUG_A_FIRST  = 3'd1;
  localparam logic [2:0] REG_PLUG_A_SECOND = 3'd2;
  localparam logic [2:0] REG_PLUG_B_FIRST  = 3'd3;
  localparam logic [2:0] REG_PLUG_B_SECOND = 3'd4;
  localparam logic [2:0] REG_PLUG_C_FIRST  = 3'd5;
  localparam logic [2:0] REG_PLUG_C_SECOND = 3'd6;

  typedef logic [NUM_PLUG_REGS-1:0][6:0] plug_regs_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic [ROT_W-1:0] rot;
    logic             wb_fwd;
    logic             wb_bwd;
    logic             lbl_cap;
    logic             scan;
    logic             load_out;
  } rcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             char_bad;
    logic             found;
    logic             exhausted;
    logic             out_busy;
    logic [ROT_W-1:0] n_last;
  } rcm_status_t;

  // plugboard: first complete pair that holds the character wins
  function automatic logic [7:0] plug_swap(input logic [7:0] c, input plug_regs_t plugs);
    logic [7:0] res;
    logic       hit;
    logic [6:0] a;
    logic [6:0] b;
    res = c;
    hit = 1'b0;
    for (int p = 0; p < NUM_PLUG_REGS / 2; p++) begin
      a = plugs[2*p];
      b = plugs[2*p+1];
      if (!hit && a != 7'd0 && b != 7'd0) begin
        if (c == {1'b0, a}) begin
          res = {1'b0, b};
          hit = 1'b1;
        end else if (c == {1'b0, b}) begin
          res = {1'b0, a};
          hit = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // reduce a value below twice the alphabet size
  function automatic logic [IDX_W-1:0] mod_alpha(input logic [7:0] v);
    logic [7:0] r;
    r = (v >= 8'(ALPHABET_SIZE)) ? v - 8'(ALPHABET_SIZE) : v;
    return r[IDX_W-1:0];
  endfunction

endpackage

[rtl/rcm_ram.sv]
// ----------------------------------------------------------------------------
// rcm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rcm_ctrl.sv]
// ----------------------------------------------------------------------------
// rcm_ctrl
// Sequencer for one translation: forward rotors, reflector scan, back rotors.
// ----------------------------------------------------------------------------
module rcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          cmd,
  output logic                in_stall,
  input  rcm_pkg::rcm_status_t st,
  output rcm_pkg::rcm_cmd_t    ctl
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_FWD_RD  = 9'b000000010,
    S_FWD_WB  = 9'b000000100,
    S_REF_RD  = 9'b000001000,
    S_REF_LBL = 9'b000010000,
    S_SCAN    = 9'b000100000,
    S_BWD_RD  = 9'b001000000,
    S_BWD_WB  = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t                    state, state_next;
  logic [rcm_pkg::ROT_W-1:0] rot, rot_next;
  logic                      accept;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    rot_next   = rot;
    case (state)
      S_IDLE: begin
        if (accept && cmd == rcm_pkg::CMD_TRANSLATE) begin
          rot_next   = '0;
          state_next = st.char_bad ? S_OUT : S_FWD_RD;
        end
      end
      S_FWD_RD:  state_next = S_FWD_WB;
      S_FWD_WB: begin
        if (rot == st.n_last) begin
          state_next = S_REF_RD;
        end else begin
          rot_next   = rot + 1'b1;
          state_next = S_FWD_RD;
        end
      end
      S_REF_RD:  state_next = S_REF_LBL;
      S_REF_LBL: state_next = S_SCAN;
      S_SCAN: begin
        if (st.found) begin
          rot_next   = st.n_last;
          state_next = S_BWD_RD;
        end else if (st.exhausted) begin
          state_next = S_OUT;
        end
      end
      S_BWD_RD:  state_next = S_BWD_WB;
      S_BWD_WB: begin
        if (rot == '0) begin
          state_next = S_OUT;
        end else begin
          rot_next   = rot - 1'b1;
          state_next = S_BWD_RD;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rot   <= '0;
    end else begin
      state <= state_next;
      rot   <= rot_next;
    end
  end

  // datapath commands
  always_comb begin
    ctl          = '0;
    ctl.accept   = accept;
    ctl.rot      = rot;
    ctl.wb_fwd   = (state == S_FWD_WB);
    ctl.wb_bwd   = (state == S_BWD_WB);
    ctl.lbl_cap  = (state == S_REF_LBL);
    ctl.scan     = (state == S_SCAN);
    ctl.load_out = (state == S_OUT) && !st.out_busy;
  end

endmodule

[rtl/rcm_datapath.sv]
// ----------------------------------------------------------------------------
// rcm_datapath
// Config registers, rotor state, wiring and label memories, output register.
// ----------------------------------------------------------------------------
module rcm_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           cmd,
  input  logic [1:0]           rotor_select,
  input  logic [6:0]           position,
  input  logic [7:0]           symbol,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [6:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           cipher_char,
  output logic                 error,
  input  rcm_pkg::rcm_cmd_t    ctl,
  output rcm_pkg::rcm_status_t st
);

  localparam int IW = rcm_pkg::IDX_W;
  localparam int RW = rcm_pkg::ROT_W;
  localparam int AW = rcm_pkg::MAP_AW;

  // configuration
  logic [2:0]          rotors_in_use;
  rcm_pkg::plug_regs_t plugs;
  logic [RW-1:0]       n_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotors_in_use <= 3'd3;
      plugs         <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rcm_pkg::REG_ROTORS:        rotors_in_use <= cfg_data[2:0];
        rcm_pkg::REG_PLUG_A_FIRST:  plugs[0]      <= cfg_data;
        rcm_pkg::REG_PLUG_A_SECOND: plugs[1]      <= cfg_data;
        rcm_pkg::REG_PLUG_B_FIRST:  plugs[2]      <= cfg_data;
        rcm_pkg::REG_PLUG_B_SECOND: plugs[3]      <= cfg_data;
        rcm_pkg::REG_PLUG_C_FIRST:  plugs[4]      <= cfg_data;
        rcm_pkg::REG_PLUG_C_SECOND: plugs[5]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp rotor count to 1..MAX_ROTORS, kept as last rotor index
  always_comb begin
    if (rotors_in_use == 3'd0) begin
      n_last = '0;
    end else if (int'(rotors_in_use) > rcm_pkg::MAX_ROTORS) begin
      n_last = RW'(rcm_pkg::MAX_ROTORS - 1);
    end else begin
      n_last = RW'(rotors_in_use - 3'd1);
    end
  end

  // input decode
  logic             sym_ok, sel_ok, pos_ok;
  logic [RW-1:0]    sel;
  logic [IW-1:0]    sym_idx;
  logic [7:0]       plugged;
  logic             char_bad;
  logic             do_load, do_label, do_start, do_xlate;

  assign sym_ok   = (symbol >= 8'(rcm_pkg::FIRST_CHAR)) && (symbol <= 8'(rcm_pkg::LAST_CHAR));
  assign sel_ok   = int'(rotor_select) < rcm_pkg::MAX_ROTORS;
  assign pos_ok   = position < 7'(rcm_pkg::ALPHABET_SIZE);
  assign sel      = RW'(rotor_select);
  assign sym_idx  = IW'(symbol - 8'(rcm_pkg::FIRST_CHAR));
  assign plugged  = rcm_pkg::plug_swap(symbol, plugs);
  assign char_bad = (plugged < 8'(rcm_pkg::FIRST_CHAR)) || (plugged > 8'(rcm_pkg::LAST_CHAR));
  assign do_load  = ctl.accept && cmd == rcm_pkg::CMD_LOAD_ROTOR && sel_ok && pos_ok && sym_ok;
  assign do_label = ctl.accept && cmd == rcm_pkg::CMD_LOAD_LABEL && pos_ok;
  assign do_start = ctl.accept && cmd == rcm_pkg::CMD_SET_START && sel_ok && sym_ok;
  assign do_xlate = ctl.accept && cmd == rcm_pkg::CMD_TRANSLATE;

  // rotor offsets and step counters, odometer stepping
  logic [IW-1:0] offset      [rcm_pkg::MAX_ROTORS];
  logic [IW-1:0] count       [rcm_pkg::MAX_ROTORS];
  logic [IW-1:0] offset_next [rcm_pkg::MAX_ROTORS];
  logic [IW-1:0] count_next  [rcm_pkg::MAX_ROTORS];

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < rcm_pkg::MAX_ROTORS; i++) begin
      offset_next[i] = offset[i];
      count_next[i]  = count[i];
      if (carry) begin
        offset_next[i] = (offset[i] == IW'(rcm_pkg::ALPHABET_SIZE - 1)) ? '0 : offset[i] + 1'b1;
        count_next[i]  = count[i] + 1'b1;
      end
      carry = 1'b0;
      if (count_next[i] >= IW'(rcm_pkg::ALPHABET_SIZE)) begin
        if (i < int'(n_last)) begin
          count_next[i] = '0;
          carry         = 1'b1;
        end else if (i == int'(n_last)) begin
          count_next[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rcm_pkg::MAX_ROTORS; i++) begin
        offset[i] <= '0;
        count[i]  <= '0;
      end
    end else if (do_xlate) begin
      for (int i = 0; i < rcm_pkg::MAX_ROTORS; i++) begin
        offset[i] <= offset_next[i];
        count[i]  <= count_next[i];
      end
    end else if (do_start) begin
      offset[sel] <= sym_idx;
      count[sel]  <= '0;
    end
  end

  // running character index, error flag, reflector scan
  logic [IW-1:0]            x;
  logic                     err;
  logic [rcm_pkg::LBL_W-1:0] target;
  logic [IW-1:0]            scan_idx;
  logic [IW-1:0]            cmp_idx;
  logic                     cmp_live;

  logic [IW-1:0] off_k;
  logic [IW-1:0] rd_idx;
  logic [AW-1:0] map_raddr;
  logic [AW-1:0] fwd_waddr, inv_waddr;
  logic [IW-1:0] fwd_rdata, inv_rdata, wb_data, a_red;
  logic [7:0]    back_sum;
  logic [IW-1:0] through;
  logic [rcm_pkg::LBL_AW-1:0] lbl_raddr;
  logic [rcm_pkg::LBL_W-1:0]  lbl_rdata;
  logic          found, exhausted;

  assign off_k     = offset[ctl.rot];
  assign rd_idx    = rcm_pkg::mod_alpha({1'b0, x} + {1'b0, off_k});
  assign map_raddr = AW'(ctl.rot) * AW'(rcm_pkg::ALPHABET_SIZE) + AW'(rd_idx);
  assign fwd_waddr = AW'(sel) * AW'(rcm_pkg::ALPHABET_SIZE) + AW'(position);
  assign inv_waddr = AW'(sel) * AW'(rcm_pkg::ALPHABET_SIZE) + AW'(sym_idx);

  // undo the offset on the table output
  assign wb_data  = ctl.wb_bwd ? inv_rdata : fwd_rdata;
  assign a_red    = rcm_pkg::mod_alpha({1'b0, wb_data});
  assign back_sum = (a_red >= off_k) ? {1'b0, a_red} - {1'b0, off_k}
                                     : {1'b0, a_red} + 8'(rcm_pkg::ALPHABET_SIZE) - {1'b0, off_k};
  assign through  = IW'(back_sum);

  assign lbl_raddr = ctl.scan ? rcm_pkg::LBL_AW'(scan_idx) : rcm_pkg::LBL_AW'(x);
  assign found     = ctl.scan && cmp_live && lbl_rdata == target && cmp_idx != x;
  assign exhausted = ctl.scan && cmp_live && !found
                     && cmp_idx == IW'(rcm_pkg::ALPHABET_SIZE - 1);

  always_ff @(posedge clk) begin
    if (do_xlate) begin
      x   <= IW'(plugged - 8'(rcm_pkg::FIRST_CHAR));
      err <= char_bad;
    end else if (ctl.wb_fwd || ctl.wb_bwd) begin
      x <= through;
    end else if (found) begin
      x <= cmp_idx;
    end else if (exhausted) begin
      err <= 1'b1;
    end
    if (ctl.lbl_cap) begin
      target   <= lbl_rdata;
      scan_idx <= '0;
    end else if (ctl.scan) begin
      cmp_idx <= scan_idx;
      if (scan_idx != IW'(rcm_pkg::ALPHABET_SIZE - 1)) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
    end else if (ctl.lbl_cap) begin
      cmp_live <= 1'b0;
    end else if (ctl.scan) begin
      cmp_live <= 1'b1;
    end
  end

  // memories
  rcm_ram #(.WIDTH(IW), .DEPTH(rcm_pkg::MAP_DEPTH)) u_fwd_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (fwd_waddr),
    .wdata (sym_idx),
    .raddr (map_raddr),
    .rdata (fwd_rdata)
  );

  rcm_ram #(.WIDTH(IW), .DEPTH(rcm_pkg::MAP_DEPTH)) u_inv_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (inv_waddr),
    .wdata (position),
    .raddr (map_raddr),
    .rdata (inv_rdata)
  );

  rcm_ram #(.WIDTH(rcm_pkg::LBL_W), .DEPTH(rcm_pkg::ALPHABET_SIZE)) u_lbl_ram (
    .clk   (clk),
    .we    (do_label),
    .waddr (rcm_pkg::LBL_AW'(position)),
    .wdata (symbol),
    .raddr (lbl_raddr),
    .rdata (lbl_rdata)
  );

  // output register
  logic [7:0] final_char;
  assign final_char = rcm_pkg::plug_swap({1'b0, x} + 8'(rcm_pkg::FIRST_CHAR), plugs);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      cipher_char <= err ? 7'd0 : final_char[6:0];
      error       <= err;
    end
  end

  // status
  always_comb begin
    st           = '0;
    st.char_bad  = char_bad;
    st.found     = found;
    st.exhausted = exhausted;
    st.out_busy  = out_valid && out_stall;
    st.n_last    = n_last;
  end

endmodule

[rtl/rotor_cipher_machine.sv]
// ----------------------------------------------------------------------------
// rotor_cipher_machine
// Rotor cipher over the printable characters '!'..'~'.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat carries cmd, rotor_select,
// position and symbol. Loads of rotor wiring, reflector labels and start
// positions complete in the accepting cycle and give no result beat.
// A translate beat yields one result beat (cipher_char, error) on the output
// channel (out_valid / out_stall). Each rotor on the way in takes a read and
// a write-back state; then the reflector label is read and the label memory
// is scanned for the matching label; each rotor on the way back again takes
// a read and a write-back state, and the result is registered. The label
// scan, one entry per cycle on the label memory read port, dominates.
// A character that leaves the alphabet at the plugboard skips to the result.
// in_stall is high from acceptance of a translate until its result is
// loaded into the output register; a waiting result does not block further
// loads, but the next result waits for the previous one to be taken.
// Configuration (cfg_valid / cfg_ready) is always ready; write only when idle.
// Reset returns registers to defaults and rotors to offset zero; the wiring
// and label memories keep whatever they held and must be loaded first.
// ----------------------------------------------------------------------------
module rotor_cipher_machine (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [1:0] rotor_select,
  input  logic [6:0] position,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] cipher_char,
  output logic       error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);

  rcm_pkg::rcm_cmd_t    ctl;
  rcm_pkg::rcm_status_t st;

  assign cfg_ready = 1'b1;

  rcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  rcm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rotor_select (rotor_select),
    .position     (position),
    .symbol       (symbol),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_char  (cipher_char),
    .error        (error),
    .ctl          (ctl),
    .st           (st)
  );

endmodule

[rtl/rcm_checker.sv]
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks on the rotor cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rcm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] cmd,
  input logic [1:0] rotor_select,
  input logic [6:0] position,
  input logic [7:0] symbol,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] cipher_char,
  input logic       error,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [2:0] cfg_index,
  input logic [6:0] cfg_data
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(cipher_char) && $stable(error))
    else $error("result payload changed under stall");

  // an error result carries a zero character
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> cipher_char == 7'd0)
    else $error("error beat with nonzero character");

  // loads never create a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd != rcm_pkg::CMD_TRANSLATE && !out_valid |=> !out_valid)
    else $error("result after a load command");

  // an accepted translate raises the input stall
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == rcm_pkg::CMD_TRANSLATE |=> in_stall)
    else $error("input not stalled during translate");

endmodule

bind rotor_cipher_machine rcm_checker u_rcm_checker (.*);
